>>> hdl/iradx_pkg.sv
// ----------------------------------------------------------------------------
// iradx_pkg
// Shared widths, command and status types and the ASCII digit mapping for
// the radix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iradx_pkg;

  localparam int VALUE_W       = 31;
  localparam int RADIX_W       = 5;
  localparam int CHAR_W        = 7;
  localparam int DIGIT_W       = 4;
  localparam int MAX_DIGITS    = 32;
  localparam int IDX_W         = $clog2(MAX_DIGITS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int BITS_PER_STEP = 8;
  localparam int WORK_W        = 32;
  localparam int DIV_STEPS     = WORK_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(8);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;

  typedef struct packed {
    logic load;
    logic div;
    logic store;
    logic start_emit;
    logic rd;
    logic slot_dec;
  } iradx_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic slot_zero;
  } iradx_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

>>> hdl/iradx_ctrl.sv
// ----------------------------------------------------------------------------
// iradx_ctrl
// Sequencer for the converter: divide loop per digit, digit store write,
// then read-back and emission of the digits, most significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iradx_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output iradx_pkg::iradx_cmd_t cmd,
  input  iradx_pkg::iradx_sts_t sts
);
  import iradx_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div  = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        step_nxt  = '0;
        state_nxt = sts.quot_zero ? S_START : S_DIV;
      end
      S_START: begin
        cmd.start_emit = 1'b1;
        state_nxt      = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.slot_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.slot_dec = 1'b1;
            state_nxt    = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

>>> hdl/iradx_dp.sv
// ----------------------------------------------------------------------------
// iradx_dp
// Datapath: radix register, shift-subtract divider (eight quotient bits per
// cycle), digit store and read-back register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iradx_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [iradx_pkg::RADIX_W-1:0]       cfg_wdata,
  input  logic [iradx_pkg::VALUE_W-1:0]       in_value,
  input  iradx_pkg::iradx_cmd_t               cmd,
  output iradx_pkg::iradx_sts_t               sts,
  output logic [iradx_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                                out_last_digit
);
  import iradx_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] radix_eff_r;
  logic [WORK_W-1:0]  work_r, work_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   slot_r;
  logic [DIGIT_W-1:0] rd_r;
  logic [DIGIT_W-1:0] store_mem [MAX_DIGITS];

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  // shift-subtract divide step
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic               q;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t        = {rem_nxt[RADIX_W-2:0], work_nxt[WORK_W-1]};
      q        = (t >= radix_eff_r);
      work_nxt = {work_nxt[WORK_W-2:0], q};
      rem_nxt  = q ? (t - radix_eff_r) : t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r <= {{(WORK_W - VALUE_W){1'b0}}, in_value};
      rem_r  <= '0;
      priority if (radix_r < RADIX_MIN) begin
        radix_eff_r <= RADIX_MIN;
      end else if (radix_r > RADIX_MAX) begin
        radix_eff_r <= RADIX_MAX;
      end else begin
        radix_eff_r <= radix_r;
      end
    end else if (cmd.div) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end else if (cmd.store) begin
      rem_r <= '0;
    end
  end

  // digit count and emission slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.store && (cnt_r < CNT_W'(MAX_DIGITS))) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_emit) begin
      slot_r <= IDX_W'(cnt_r - CNT_W'(1));
    end else if (cmd.slot_dec) begin
      slot_r <= slot_r - IDX_W'(1);
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.store && (cnt_r < CNT_W'(MAX_DIGITS))) begin
      store_mem[cnt_r[IDX_W-1:0]] <= rem_r[DIGIT_W-1:0];
    end
    if (cmd.rd) begin
      rd_r <= store_mem[slot_r];
    end
  end

  assign sts.quot_zero  = (work_r == '0);
  assign sts.slot_zero  = (slot_r == '0);
  assign out_digit_char = digit_to_ascii(rd_r);
  assign out_last_digit = sts.slot_zero;

endmodule

>>> hdl/integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a 31-bit non-negative integer to upper-case ASCII digits in the
// radix held in the configuration register (2 to 16; 0 and 1 act as 2, values
// above 16 act as 16; reset 8). One request in gives one request out per
// digit, most significant first, with out_last_digit set on the final one;
// zero gives a single "0". A new value is taken only after the last digit of
// the previous one has gone out. Each digit is found by the shift-subtract
// divider (eight quotient bits per cycle) and then written to the digit
// store; once all are found, each digit is read back from the store and
// then presented on the output. Write the radix only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_radix_ascii (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [iradx_pkg::RADIX_W-1:0]  cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [iradx_pkg::VALUE_W-1:0]  in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [iradx_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                           out_last_digit
);
  import iradx_pkg::*;

  iradx_cmd_t cmd;
  iradx_sts_t sts;

  iradx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  iradx_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule
